// File: rtl/affine_texture_composite_unit_macros.svh
// Assertion helpers shared by the texture compositing RTL.
// Both forms sample on clk_i and are quiet while rst_ni is low.
`ifndef AFFINE_TEXTURE_COMPOSITE_UNIT_MACROS_SVH
`define AFFINE_TEXTURE_COMPOSITE_UNIT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ATC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ATC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/atc_pkg.sv
`timescale 1ns / 1ps

package atc_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_CORNER_X = 3'd0,
    CFG_CORNER_Y = 3'd1,
    CFG_U_EDGE_X = 3'd2,
    CFG_U_EDGE_Y = 3'd3,
    CFG_V_EDGE_X = 3'd4,
    CFG_V_EDGE_Y = 3'd5,
    CFG_GAIN     = 3'd6
  } cfg_reg_e;

  // Item kinds
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_PAINT = 1'b1
  } action_e;

  // Pixels at or beyond this column or row are never covered
  localparam int unsigned FRAME_MAX = 4096;

  localparam int unsigned STORE_DEPTH = 65536;

  // Gain saturates at 60000.0 in Q16.8
  localparam logic [23:0] GAIN_CAP = 24'd15360000;

  // ceil(2^32 / 255): exact floor division by 255 for values below 2^24
  localparam logic [24:0] RECIP_255_Q32 = 25'd16843010;

  // ceil(2^39 / 255): exact floor division by 255 for any 32-bit value
  localparam logic [31:0] RECIP_255_Q39 = 32'h80808081;

  // Control bits that travel with every pipeline stage
  typedef struct packed {
    logic vld;
    logic paint;
    logic cov;
  } ctl_t;

  // Texel write carried down to the texture fetch stage
  typedef struct packed {
    logic [15:0] idx;
    logic [31:0] argb;
  } load_t;

endpackage

// File: rtl/affine_texture_composite_unit.sv
// Texture compositor: load items write one ARGB texel into a 64K x 32 texture store, paint
// items return one result (covered flag and red/green/blue Q16.8 additions) per pixel. The
// block takes one item per clock; a paint result passes through the 17-stage
// restoring divider that solves u and v and the 17-stage square root of the gamma
// curve. A load reaches the store at the fetch stage, so paints see loads in item
// order. The store is kept in two copies, each read at two addresses per cycle, to
// fetch the four bilinear texels together; it is not cleared, and a texel must be loaded
// before a paint samples it. A stall on the result side holds the whole pipeline.
`timescale 1ns / 1ps
`include "affine_texture_composite_unit_macros.svh"

module affine_texture_composite_unit #(
  parameter int TEX_W = 256,
  parameter int TEX_H = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [15:0] texel_index_i,
  input  logic [31:0] texel_argb_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        covered_o,
  output logic [23:0] add_red_o,
  output logic [23:0] add_green_o,
  output logic [23:0] add_blue_o
);

  localparam int CW = $clog2(TEX_W);
  localparam int RW = $clog2(TEX_H);
  localparam logic [CW-1:0] WM1 = CW'(TEX_W - 1);
  localparam logic [RW-1:0] HM1 = RW'(TEX_H - 1);

  localparam int DIV_N = 17;
  localparam int SQ_N  = 17;

  // Stage positions
  localparam int ST_RATIO   = 3;
  localparam int ST_DIV0    = 4;
  localparam int ST_DIVL    = ST_DIV0 + DIV_N - 1;
  localparam int ST_TC      = ST_DIVL + 1;
  localparam int ST_ADDR    = ST_TC + 1;
  localparam int ST_FETCH   = ST_ADDR + 1;
  localparam int ST_PROD    = ST_FETCH + 1;
  localparam int ST_BLEND   = ST_PROD + 1;
  localparam int ST_NORM    = ST_BLEND + 1;
  localparam int ST_SQ0     = ST_NORM + 1;
  localparam int ST_OUT     = ST_SQ0 + SQ_N + 3;
  localparam int NST        = ST_OUT + 1;

  localparam logic [16:0] FRAME_LIM = 17'(atc_pkg::FRAME_MAX);

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [23:0] corner_x_q, corner_y_q, u_edge_x_q, u_edge_y_q;
  logic [23:0] v_edge_x_q, v_edge_y_q, gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      corner_x_q <= '0;
      corner_y_q <= '0;
      u_edge_x_q <= '0;
      u_edge_y_q <= '0;
      v_edge_x_q <= '0;
      v_edge_y_q <= '0;
      gain_q     <= '0;
    end else if (cfg_we_i) begin
      case (atc_pkg::cfg_reg_e'(cfg_idx_i))
        atc_pkg::CFG_CORNER_X: corner_x_q <= cfg_wdata_i;
        atc_pkg::CFG_CORNER_Y: corner_y_q <= cfg_wdata_i;
        atc_pkg::CFG_U_EDGE_X: u_edge_x_q <= cfg_wdata_i;
        atc_pkg::CFG_U_EDGE_Y: u_edge_y_q <= cfg_wdata_i;
        atc_pkg::CFG_V_EDGE_X: v_edge_x_q <= cfg_wdata_i;
        atc_pkg::CFG_V_EDGE_Y: v_edge_y_q <= cfg_wdata_i;
        atc_pkg::CFG_GAIN:     gain_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic signed [23:0] cx_s, cy_s, ux_s, uy_s, vx_s, vy_s;
  logic [23:0] gain_sat;

  assign cx_s = $signed(corner_x_q);
  assign cy_s = $signed(corner_y_q);
  assign ux_s = $signed(u_edge_x_q);
  assign uy_s = $signed(u_edge_y_q);
  assign vx_s = $signed(v_edge_x_q);
  assign vy_s = $signed(v_edge_y_q);
  assign gain_sat = (gain_q > atc_pkg::GAIN_CAP) ? atc_pkg::GAIN_CAP : gain_q;

  // ---------------------------------------------------------------
  // Pipeline advance and control bits
  // ---------------------------------------------------------------
  logic en;
  atc_pkg::ctl_t ctl_q [NST];
  atc_pkg::ctl_t ctl_d [NST];
  atc_pkg::load_t ld_q [ST_ADDR + 1];
  logic ratio_ok, alpha_ok, in_frame;

  assign out_valid_o = ctl_q[ST_OUT].vld && ctl_q[ST_OUT].paint;
  assign en          = !(out_valid_o && out_stall_i);
  assign in_stall_o  = !en;

  assign in_frame = ({5'd0, pixel_x_i} < FRAME_LIM) && ({5'd0, pixel_y_i} < FRAME_LIM);

  // Shift control; drop coverage at the ratio and alpha checks
  always_comb begin
    ctl_d[0].vld   = in_valid_i;
    ctl_d[0].paint = (atc_pkg::action_e'(action_i) == atc_pkg::ACT_PAINT);
    ctl_d[0].cov   = in_frame;
    for (int i = 1; i < NST; i++) begin
      ctl_d[i] = ctl_q[i-1];
    end
    ctl_d[ST_RATIO].cov = ctl_q[ST_RATIO-1].cov && ratio_ok;
    ctl_d[ST_BLEND].cov = ctl_q[ST_BLEND-1].cov && alpha_ok;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NST; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q <= ctl_d;
    end
  end

  // Carry load items down to the fetch stage
  always_ff @(posedge clk_i) begin
    if (en) begin
      ld_q[0] <= {texel_index_i, texel_argb_i};
      for (int i = 1; i <= ST_ADDR; i++) begin
        ld_q[i] <= ld_q[i-1];
      end
    end
  end

  // ---------------------------------------------------------------
  // Affine solve: offsets, determinant, numerators
  // ---------------------------------------------------------------
  logic signed [25:0] rx_q, ry_q;
  logic signed [47:0] pdet_a_q, pdet_b_q;
  logic signed [48:0] det1_q, det2_q;
  logic signed [49:0] na_q, nb_q, nc_q, nd_q;
  logic signed [50:0] nu_q, nv_q;
  logic [49:0] dabs_q, ru_q, rv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q     <= $signed({6'd0, pixel_x_i, 8'd0}) - {{2{cx_s[23]}}, cx_s};
      ry_q     <= $signed({6'd0, pixel_y_i, 8'd0}) - {{2{cy_s[23]}}, cy_s};
      pdet_a_q <= ux_s * vy_s;
      pdet_b_q <= uy_s * vx_s;

      det1_q   <= {pdet_a_q[47], pdet_a_q} - {pdet_b_q[47], pdet_b_q};
      na_q     <= rx_q * vy_s;
      nb_q     <= ry_q * vx_s;
      nc_q     <= ry_q * ux_s;
      nd_q     <= rx_q * uy_s;

      det2_q   <= det1_q;
      nu_q     <= {na_q[49], na_q} - {nb_q[49], nb_q};
      nv_q     <= {nc_q[49], nc_q} - {nd_q[49], nd_q};
    end
  end

  // Fold the determinant sign into the numerators and check det != 0 and 0 <= num <= det
  logic [50:0] det_w, dabs_w, nu_w, nv_w;

  always_comb begin
    det_w    = {{2{det2_q[48]}}, det2_q};
    dabs_w   = det2_q[48] ? (51'd0 - det_w) : det_w;
    nu_w     = det2_q[48] ? (51'd0 - nu_q) : nu_q;
    nv_w     = det2_q[48] ? (51'd0 - nv_q) : nv_q;
    ratio_ok = (det2_q != '0) && !nu_w[50] && !nv_w[50] &&
               (nu_w <= dabs_w) && (nv_w <= dabs_w);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dabs_q <= dabs_w[49:0];
      ru_q   <= nu_w[49:0];
      rv_q   <= nv_w[49:0];
    end
  end

  // ---------------------------------------------------------------
  // Restoring divider: one quotient bit per stage, u and v side by side
  // ---------------------------------------------------------------
  logic [49:0] dd_q  [DIV_N];
  logic [49:0] dru_q [DIV_N];
  logic [49:0] drv_q [DIV_N];
  logic [16:0] dqu_q [DIV_N];
  logic [16:0] dqv_q [DIV_N];
  logic [49:0] dd_d  [DIV_N];
  logic [49:0] dru_d [DIV_N];
  logic [49:0] drv_d [DIV_N];
  logic [16:0] dqu_d [DIV_N];
  logic [16:0] dqv_d [DIV_N];

  function automatic logic [50:0] div_step(input logic [50:0] trial, input logic [49:0] d);
    logic        hit;
    logic [50:0] diff;
    diff = trial - {1'b0, d};
    hit  = (trial >= {1'b0, d});
    return {hit, hit ? diff[49:0] : trial[49:0]};
  endfunction

  always_comb begin
    logic bu, bv;
    {bu, dru_d[0]} = div_step({1'b0, ru_q}, dabs_q);
    {bv, drv_d[0]} = div_step({1'b0, rv_q}, dabs_q);
    dqu_d[0] = {16'd0, bu};
    dqv_d[0] = {16'd0, bv};
    dd_d[0]  = dabs_q;
    for (int j = 1; j < DIV_N; j++) begin
      {bu, dru_d[j]} = div_step({dru_q[j-1], 1'b0}, dd_q[j-1]);
      {bv, drv_d[j]} = div_step({drv_q[j-1], 1'b0}, dd_q[j-1]);
      dqu_d[j] = {dqu_q[j-1][15:0], bu};
      dqv_d[j] = {dqv_q[j-1][15:0], bv};
      dd_d[j]  = dd_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dd_q  <= dd_d;
      dru_q <= dru_d;
      drv_q <= drv_d;
      dqu_q <= dqu_d;
      dqv_q <= dqv_d;
    end
  end

  // ---------------------------------------------------------------
  // Texture coordinates, addresses and bilinear weights
  // ---------------------------------------------------------------
  logic [16+CW-1:0] tu_q;
  logic [16+RW-1:0] tv_q;
  logic [15:0] addr_q [4];
  logic [32:0] w_q    [4];
  logic [32:0] wf_q   [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      tu_q <= (16+CW)'({{CW{1'b0}}, dqu_q[DIV_N-1]} * {17'd0, WM1});
      tv_q <= (16+RW)'({{RW{1'b0}}, dqv_q[DIV_N-1]} * {17'd0, HM1});
    end
  end

  logic [15:0] addr_d [4];
  logic [32:0] w_d    [4];

  always_comb begin
    logic [CW-1:0] c0, c1;
    logic [RW-1:0] r0, r1;
    logic [CW:0]   c0p;
    logic [RW:0]   r0p;
    logic [16:0]   fx, fy, ifx, ify;
    c0  = tu_q[16+CW-1:16];
    r0  = tv_q[16+RW-1:16];
    c0p = {1'b0, c0} + 1'b1;
    r0p = {1'b0, r0} + 1'b1;
    c1  = (c0p < {1'b0, WM1}) ? c0p[CW-1:0] : WM1;
    r1  = (r0p < {1'b0, HM1}) ? r0p[RW-1:0] : HM1;
    fx  = {1'b0, tu_q[15:0]};
    fy  = {1'b0, tv_q[15:0]};
    ifx = 17'h10000 - fx;
    ify = 17'h10000 - fy;
    addr_d[0] = 16'(32'(r0) * 32'(TEX_W) + 32'(c0));
    addr_d[1] = 16'(32'(r0) * 32'(TEX_W) + 32'(c1));
    addr_d[2] = 16'(32'(r1) * 32'(TEX_W) + 32'(c0));
    addr_d[3] = 16'(32'(r1) * 32'(TEX_W) + 32'(c1));
    w_d[0] = 33'({17'd0, ifx} * {17'd0, ify});
    w_d[1] = 33'({17'd0, fx} * {17'd0, ify});
    w_d[2] = 33'({17'd0, ifx} * {17'd0, fy});
    w_d[3] = 33'({17'd0, fx} * {17'd0, fy});
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      addr_q <= addr_d;
      w_q    <= w_d;
    end
  end

  // ---------------------------------------------------------------
  // Texture store: two copies, each written by loads, read at two addresses
  // ---------------------------------------------------------------
  logic [31:0] tex_a_q [atc_pkg::STORE_DEPTH];
  logic [31:0] tex_b_q [atc_pkg::STORE_DEPTH];
  logic [31:0] texel_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (ctl_q[ST_ADDR].vld && !ctl_q[ST_ADDR].paint) begin
        tex_a_q[ld_q[ST_ADDR].idx] <= ld_q[ST_ADDR].argb;
        tex_b_q[ld_q[ST_ADDR].idx] <= ld_q[ST_ADDR].argb;
      end
      texel_q[0] <= tex_a_q[addr_q[0]];
      texel_q[1] <= tex_a_q[addr_q[1]];
      texel_q[2] <= tex_b_q[addr_q[2]];
      texel_q[3] <= tex_b_q[addr_q[3]];
      wf_q       <= w_q;
    end
  end

  // ---------------------------------------------------------------
  // Bilinear blend: weighted channel products, then sums
  // ---------------------------------------------------------------
  logic [39:0] prod_q [4][4];
  logic [23:0] c_q    [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 4; i++) begin
          prod_q[k][i] <= {32'd0, texel_q[i][31-8*k -: 8]} * {7'd0, wf_q[i]};
        end
      end
    end
  end

  logic [39:0] sum_d [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      sum_d[k] = prod_q[k][0] + prod_q[k][1] + prod_q[k][2] + prod_q[k][3];
    end
    alpha_ok = (sum_d[0][39:32] != 8'd0);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        c_q[k] <= sum_d[k][39:16];
      end
    end
  end

  // ---------------------------------------------------------------
  // Normalize: n = c / 255 by reciprocal
  // ---------------------------------------------------------------
  logic [16:0] n_q [3];
  logic [23:0] a16_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        n_q[k] <= 17'(({25'd0, c_q[k+1]} * {24'd0, atc_pkg::RECIP_255_Q32}) >> 32);
      end
      a16_q <= c_q[0];
    end
  end

  // ---------------------------------------------------------------
  // Square root of n * 2^16: one result bit per stage; n^2 rides along
  // ---------------------------------------------------------------
  logic [33:0] sx_q  [SQ_N][3];
  logic [33:0] sr_q  [SQ_N][3];
  logic [16:0] sn2_q [SQ_N][3];
  logic [23:0] sa_q  [SQ_N];
  logic [33:0] sx_d  [SQ_N][3];
  logic [33:0] sr_d  [SQ_N][3];
  logic [16:0] sn2_d [SQ_N][3];
  logic [23:0] sa_d  [SQ_N];

  function automatic logic [67:0] sq_step(input logic [33:0] x, input logic [33:0] r,
                                          input logic [33:0] b);
    logic [33:0] t;
    t = r + b;
    if (x >= t) begin
      return {x - t, (r >> 1) + b};
    end
    return {x, r >> 1};
  endfunction

  always_comb begin
    logic [33:0] n2w;
    for (int k = 0; k < 3; k++) begin
      n2w = {17'd0, n_q[k]} * {17'd0, n_q[k]};
      sn2_d[0][k] = n2w[32:16];
      {sx_d[0][k], sr_d[0][k]} = sq_step({1'b0, n_q[k], 16'd0}, 34'd0, 34'd1 << 32);
    end
    sa_d[0] = a16_q;
    for (int j = 1; j < SQ_N; j++) begin
      for (int k = 0; k < 3; k++) begin
        {sx_d[j][k], sr_d[j][k]} = sq_step(sx_q[j-1][k], sr_q[j-1][k],
                                           34'd1 << (32 - 2 * j));
        sn2_d[j][k] = sn2_q[j-1][k];
      end
      sa_d[j] = sa_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= sx_d;
      sr_q  <= sr_d;
      sn2_q <= sn2_d;
      sa_q  <= sa_d;
    end
  end

  // ---------------------------------------------------------------
  // Gamma product, gain, alpha scaling
  // ---------------------------------------------------------------
  logic [16:0] g_q  [3];
  logic [23:0] t_q  [3];
  logic [31:0] x_q  [3];
  logic [23:0] ag_q, at_q;
  logic [23:0] add_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        g_q[k] <= 17'(({17'd0, sn2_q[SQ_N-1][k]} * {17'd0, sr_q[SQ_N-1][k][16:0]}) >> 16);
        t_q[k] <= 24'(({24'd0, g_q[k]} * {17'd0, gain_sat}) >> 16);
        x_q[k] <= 32'(({24'd0, t_q[k]} * {24'd0, at_q}) >> 16);
      end
      ag_q <= sa_q[SQ_N-1];
      at_q <= ag_q;
    end
  end

  // Final divide by 255 into the output register; zero when not covered
  always_ff @(posedge clk_i) begin
    logic [63:0] qw;
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        qw = {32'd0, x_q[k]} * {32'd0, atc_pkg::RECIP_255_Q39};
        add_q[k] <= ctl_q[ST_OUT-1].cov ? qw[62:39] : 24'd0;
      end
    end
  end

  assign covered_o   = ctl_q[ST_OUT].cov;
  assign add_red_o   = add_q[0];
  assign add_green_o = add_q[1];
  assign add_blue_o  = add_q[2];

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  `ATC_ASSERT_NOW(a_uncov_zero, out_valid_o && !covered_o, add_red_o == 24'd0 && add_green_o == 24'd0 && add_blue_o == 24'd0, "uncovered result carries nonzero additions")
  `ATC_ASSERT_NEXT(a_cov_sticky, en && ctl_q[ST_DIV0].vld && !ctl_q[ST_DIV0].cov, !ctl_q[ST_DIV0+1].cov, "coverage reappeared after rejection")
  `ATC_ASSERT_NOW(a_quot_range, ctl_q[ST_DIVL].vld && ctl_q[ST_DIVL].cov, dqu_q[DIV_N-1] <= 17'd65536 && dqv_q[DIV_N-1] <= 17'd65536, "covered u or v quotient above one")
  `ATC_ASSERT_NOW(a_alpha_floor, ctl_q[ST_BLEND].vld && ctl_q[ST_BLEND].cov, c_q[0] >= 24'h010000, "covered item with blended alpha below one")

endmodule

// File: tb/sv/affine_texture_composite_unit_checker.sv
`timescale 1ns / 1ps

module affine_texture_composite_unit_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_wdata_i,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        action_i,
  input  logic [15:0] texel_index_i,
  input  logic [31:0] texel_argb_i,
  input  logic [11:0] pixel_x_i,
  input  logic [11:0] pixel_y_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        covered_i,
  input  logic [23:0] add_red_i,
  input  logic [23:0] add_green_i,
  input  logic [23:0] add_blue_i,
  output int          failures_o,
  output int          pending_o
);

  localparam int TEX_W = 256;
  localparam int TEX_H = 256;

  typedef struct packed {
    logic        covered;
    logic [23:0] red;
    logic [23:0] green;
    logic [23:0] blue;
  } pixel_add_t;

  logic signed [23:0] corner_x, corner_y, u_edge_x, u_edge_y, v_edge_x, v_edge_y;
  logic [23:0]        gain;
  logic [31:0]        texels [atc_pkg::STORE_DEPTH];
  pixel_add_t         pixel_adds_q [$];

  assign pending_o = pixel_adds_q.size();

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Solve one edge ratio; fail when it leaves [0,1]
  function automatic bit edge_ratio(input longint num, input longint det,
                                    output longint unsigned q);
    if (det < 0) begin
      det = -det;
      num = -num;
    end
    q = 0;
    if (num < 0 || num > det) return 0;
    q = (longint'(num) << 16) / longint'(det);
    return 1;
  endfunction

  // Map a pixel to its four texel addresses and the bilinear fractions
  function automatic bit locate(input logic [11:0] px, input logic [11:0] py,
                                output logic [15:0] addr [4],
                                output logic [15:0] fx, output logic [15:0] fy);
    longint rx, ry, det;
    longint unsigned uq, vq, tu, tv, c0, r0, c1, r1;
    for (int i = 0; i < 4; i++) addr[i] = '0;
    fx = '0;
    fy = '0;
    if (px >= atc_pkg::FRAME_MAX || py >= atc_pkg::FRAME_MAX) return 0;
    rx  = longint'(px) * 256 - longint'(corner_x);
    ry  = longint'(py) * 256 - longint'(corner_y);
    det = longint'(u_edge_x) * longint'(v_edge_y) - longint'(u_edge_y) * longint'(v_edge_x);
    if (det == 0) return 0;
    if (!edge_ratio(rx * longint'(v_edge_y) - ry * longint'(v_edge_x), det, uq)) return 0;
    if (!edge_ratio(ry * longint'(u_edge_x) - rx * longint'(u_edge_y), det, vq)) return 0;
    tu = uq * (TEX_W - 1);
    tv = vq * (TEX_H - 1);
    c0 = tu >> 16;
    r0 = tv >> 16;
    fx = tu[15:0];
    fy = tv[15:0];
    c1 = (c0 + 1 < TEX_W - 1) ? c0 + 1 : TEX_W - 1;
    r1 = (r0 + 1 < TEX_H - 1) ? r0 + 1 : TEX_H - 1;
    addr[0] = 16'(r0 * TEX_W + c0);
    addr[1] = 16'(r0 * TEX_W + c1);
    addr[2] = 16'(r1 * TEX_W + c0);
    addr[3] = 16'(r1 * TEX_W + c1);
    return 1;
  endfunction

  // Gamma, gain and alpha scaling of one blended channel
  function automatic logic [23:0] shade(input longint unsigned c16,
                                        input longint unsigned a16,
                                        input longint unsigned g_sat);
    longint unsigned n, n2, s, g, t;
    n  = c16 / 255;
    n2 = (n * n) >> 16;
    s  = isqrt(n << 16);
    g  = (n2 * s) >> 16;
    t  = (g * g_sat) >> 16;
    return 24'((t * a16) / (64'd255 << 16));
  endfunction

  function automatic pixel_add_t paint_pixel(input logic [11:0] px, input logic [11:0] py);
    logic [15:0]     addr [4];
    logic [15:0]     fx, fy;
    longint unsigned w [4];
    longint unsigned sum [4];
    longint unsigned g_sat;
    logic [31:0]     p;
    pixel_add_t      r;
    r = '0;
    if (!locate(px, py, addr, fx, fy)) return r;
    w[0] = (65536 - longint'(fx)) * (65536 - longint'(fy));
    w[1] = longint'(fx) * (65536 - longint'(fy));
    w[2] = (65536 - longint'(fx)) * longint'(fy);
    w[3] = longint'(fx) * longint'(fy);
    for (int k = 0; k < 4; k++) sum[k] = 0;
    for (int i = 0; i < 4; i++) begin
      p = texels[addr[i]];
      for (int k = 0; k < 4; k++) sum[k] += longint'(p[31 - 8 * k -: 8]) * w[i];
    end
    // drop pixels whose blended alpha is below one
    if (sum[0] < (64'd1 << 32)) return r;
    g_sat     = (gain > atc_pkg::GAIN_CAP) ? atc_pkg::GAIN_CAP : gain;
    r.covered = 1'b1;
    r.red     = shade(sum[1] >> 16, sum[0] >> 16, g_sat);
    r.green   = shade(sum[2] >> 16, sum[0] >> 16, g_sat);
    r.blue    = shade(sum[3] >> 16, sum[0] >> 16, g_sat);
    return r;
  endfunction

  // Track config, predict accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_add_t exp_add;
    if (!rst_ni) begin
      corner_x   = '0;
      corner_y   = '0;
      u_edge_x   = '0;
      u_edge_y   = '0;
      v_edge_x   = '0;
      v_edge_y   = '0;
      gain       = '0;
      failures_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (atc_pkg::cfg_reg_e'(cfg_idx_i))
          atc_pkg::CFG_CORNER_X: corner_x = cfg_wdata_i;
          atc_pkg::CFG_CORNER_Y: corner_y = cfg_wdata_i;
          atc_pkg::CFG_U_EDGE_X: u_edge_x = cfg_wdata_i;
          atc_pkg::CFG_U_EDGE_Y: u_edge_y = cfg_wdata_i;
          atc_pkg::CFG_V_EDGE_X: v_edge_x = cfg_wdata_i;
          atc_pkg::CFG_V_EDGE_Y: v_edge_y = cfg_wdata_i;
          atc_pkg::CFG_GAIN:     gain     = cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (pixel_adds_q.size() == 0) begin
          $error("result with no item waiting");
          failures_o = failures_o + 1;
        end else begin
          exp_add = pixel_adds_q.pop_front();
          if (covered_i !== exp_add.covered) begin
            $error("covered: expected %0d actual %0d", exp_add.covered, covered_i);
            failures_o = failures_o + 1;
          end
          if (add_red_i !== exp_add.red) begin
            $error("add_red: expected %0d actual %0d", exp_add.red, add_red_i);
            failures_o = failures_o + 1;
          end
          if (add_green_i !== exp_add.green) begin
            $error("add_green: expected %0d actual %0d", exp_add.green, add_green_i);
            failures_o = failures_o + 1;
          end
          if (add_blue_i !== exp_add.blue) begin
            $error("add_blue: expected %0d actual %0d", exp_add.blue, add_blue_i);
            failures_o = failures_o + 1;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (atc_pkg::action_e'(action_i) == atc_pkg::ACT_LOAD) begin
          texels[texel_index_i] = texel_argb_i;
        end else begin
          pixel_adds_q.insert(pixel_adds_q.size(), paint_pixel(pixel_x_i, pixel_y_i));
        end
      end
    end
  end

endmodule

// File: tb/sv/affine_texture_composite_unit_test.sv
`timescale 1ns / 1ps

module affine_texture_composite_unit_test;

  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 1000000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        action_i = 1'b0;
  logic [15:0] texel_index_i = '0;
  logic [31:0] texel_argb_i = '0;
  logic [11:0] pixel_x_i = '0;
  logic [11:0] pixel_y_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        covered_o;
  logic [23:0] add_red_o, add_green_o, add_blue_o;
  int          failures, pending;
  int          cycles = 0;
  bit          calm;
  bit          loaded [atc_pkg::STORE_DEPTH];
  int          cx, cy, uxp, uyp, vxp, vyp;

  always #5 clk_i = ~clk_i;

  affine_texture_composite_unit u_dut (.*);

  affine_texture_composite_unit_checker u_chk (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_stall_i(in_stall_o), .action_i, .texel_index_i, .texel_argb_i,
    .pixel_x_i, .pixel_y_i, .out_valid_i(out_valid_o), .out_stall_i,
    .covered_i(covered_o), .add_red_i(add_red_o), .add_green_i(add_green_o),
    .add_blue_i(add_blue_o), .failures_o(failures), .pending_o(pending)
  );

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("affine_texture_composite_unit regression: fail");
      $finish;
    end
  end

  // Stall the result side at random
  initial begin
    int  hold;
    bit  v;
    forever begin
      hold = calm ? 0 : $urandom_range(0, 14);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do begin
        @(negedge clk_i);
        v = out_valid_o;
        @(posedge clk_i);
      end while (!v);
    end
  end

  // Drive one item and hold it until taken
  task automatic send(input atc_pkg::action_e act, input logic [15:0] idx,
                      input logic [31:0] argb,
                      input logic [11:0] px, input logic [11:0] py);
    int gap;
    bit s;
    gap = calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    texel_index_i <= idx;
    texel_argb_i  <= argb;
    pixel_x_i     <= px;
    pixel_y_i     <= py;
    do begin
      @(negedge clk_i);
      s = in_stall_o;
      @(posedge clk_i);
    end while (s);
  endtask

  function automatic logic [31:0] rand_texel();
    logic [31:0] t;
    t = $urandom;
    case ($urandom_range(0, 6))
      0: t[31:24] = 8'h00;
      1: t[31:24] = 8'hFF;
      2: t = 32'hFFFFFFFF;
      default: ;
    endcase
    return t;
  endfunction

  task automatic load(input logic [15:0] idx, input logic [31:0] argb);
    loaded[idx] = 1'b1;
    send(atc_pkg::ACT_LOAD, idx, argb, 12'($urandom), 12'($urandom));
  endtask

  // Paint a pixel, first loading its unwritten texels, or all four with zero alpha
  task automatic paint(input logic [11:0] px, input logic [11:0] py, input bit clear_alpha);
    logic [15:0] addr [4];
    logic [15:0] fx, fy;
    if (u_chk.locate(px, py, addr, fx, fy)) begin
      for (int i = 0; i < 4; i++) begin
        if (clear_alpha) load(addr[i], {8'h00, 24'($urandom)});
        else if (!loaded[addr[i]]) load(addr[i], rand_texel());
      end
    end
    send(atc_pkg::ACT_PAINT, 16'($urandom), $urandom, px, py);
  endtask

  // Write the registers once the pipeline has drained
  task automatic configure(input logic [23:0] c_x, input logic [23:0] c_y,
                           input logic [23:0] u_x, input logic [23:0] u_y,
                           input logic [23:0] v_x, input logic [23:0] v_y,
                           input logic [23:0] g);
    logic [23:0] vals [7];
    vals = '{c_x, c_y, u_x, u_y, v_x, v_y, g};
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    for (int i = 0; i < 7; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= 3'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int signed_span();
    int len;
    len = $urandom_range(16, 1000);
    return $urandom_range(0, 1) ? len : -len;
  endfunction

  task automatic random_geometry();
    logic [23:0] g;
    cx  = $urandom_range(0, 4095);
    cy  = $urandom_range(0, 4095);
    uxp = signed_span();
    vyp = signed_span();
    uyp = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 300) - 150;
    vxp = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 300) - 150;
    case ($urandom_range(0, 9))
      0: g = '0;
      1: g = $urandom_range(atc_pkg::GAIN_CAP, 24'hFFFFFF);
      default: g = $urandom_range(0, atc_pkg::GAIN_CAP);
    endcase
    configure(24'(cx * 256 + $urandom_range(0, 255)), 24'(cy * 256 + $urandom_range(0, 255)),
              24'(uxp * 256 + $urandom_range(0, 255)), 24'(uyp * 256 + $urandom_range(0, 255)),
              24'(vxp * 256 + $urandom_range(0, 255)), 24'(vyp * 256 + $urandom_range(0, 255)),
              g);
  endtask

  function automatic logic [11:0] clamp_px(input int p);
    return (p < 0) ? 12'd0 : (p > 4095) ? 12'd4095 : 12'(p);
  endfunction

  // Mostly pixels over the texture quad, some anywhere, some noise loads
  task automatic random_items(input int n, input bit pause_midway);
    int su, sv;
    for (int k = 0; k < n; k++) begin
      if (k % 16 == 0) calm = ($urandom_range(0, 3) == 0);
      if (pause_midway && k == n / 2) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (pending != 0) @(posedge clk_i);
      end
      case ($urandom_range(0, 19))
        0, 1: load(16'($urandom), $urandom);
        2, 3: paint(12'($urandom), 12'($urandom), 1'b0);
        4:    begin
          su = $urandom_range(0, 1000);
          sv = $urandom_range(0, 1000);
          paint(clamp_px(cx + uxp * su / 1000 + vxp * sv / 1000),
                clamp_px(cy + uyp * su / 1000 + vyp * sv / 1000), 1'b1);
        end
        default: begin
          su = $urandom_range(0, 1100) - 50;
          sv = $urandom_range(0, 1100) - 50;
          paint(clamp_px(cx + uxp * su / 1000 + vxp * sv / 1000),
                clamp_px(cy + uyp * su / 1000 + vyp * sv / 1000), 1'b0);
        end
      endcase
    end
  endtask

  initial begin
    calm   = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers give a zero determinant
    paint(12'd0, 12'd0, 1'b0);
    paint(12'd4095, 12'd4095, 1'b0);

    // Square quad at 100,100 of 200 pixels, gain above its cap
    cx = 100; cy = 100; uxp = 200; uyp = 0; vxp = 0; vyp = 200;
    configure(24'd25600, 24'd25600, 24'd51200, 24'd0, 24'd0, 24'd51200, 24'hFFFFFF);
    load(16'h0000, 32'h00000000);
    load(16'hFFFF, 32'hFFFFFFFF);
    paint(12'd100, 12'd100, 1'b0);
    paint(12'd300, 12'd300, 1'b0);
    paint(12'd300, 12'd100, 1'b0);
    paint(12'd100, 12'd300, 1'b0);
    paint(12'd99, 12'd100, 1'b0);
    paint(12'd100, 12'd301, 1'b0);
    paint(12'd200, 12'd150, 1'b0);
    paint(12'd150, 12'd150, 1'b1);
    paint(12'd0, 12'd0, 1'b0);
    paint(12'd4095, 12'd4095, 1'b0);

    // Extreme registers, then a mirrored quad with negative determinant and zero gain
    configure(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
              24'd15360000);
    paint(12'd0, 12'd0, 1'b0);
    paint(12'd4095, 12'd4095, 1'b0);
    paint(12'd4095, 12'd0, 1'b0);
    cx = 3000; cy = 3000; uxp = -500; uyp = 0; vxp = 0; vyp = -500;
    configure(24'(3000 * 256), 24'(3000 * 256), 24'(-500 * 256), 24'd0, 24'd0,
              24'(500 * 256), 24'd0);
    vyp = 500;
    random_items(40, 1'b0);

    for (int ph = 0; ph < 7; ph++) begin
      random_geometry();
      random_items(66, ph == 2);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (failures == 0 && pending == 0) begin
      $display("affine_texture_composite_unit regression: pass");
    end else begin
      $display("affine_texture_composite_unit regression: fail");
    end
    $finish;
  end

endmodule

// File: affine_texture_composite_unit.f
+incdir+rtl
rtl/atc_pkg.sv
rtl/affine_texture_composite_unit.sv
tb/sv/affine_texture_composite_unit_checker.sv
tb/sv/affine_texture_composite_unit_test.sv
